>>> sv/iida_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iida_pkg: shared definitions for the indexed insert/delete array
// Capacity, word width, command and status codes, array operation struct.
// ----------------------------------------------------------------------------
package iida_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  // Port field widths
  localparam int CMD_W   = 3;
  localparam int IDX_IN_W = 5;
  localparam int VAL_W   = 32;
  localparam int CNTO_W  = 5;
  localparam int STAT_W  = 2;

  // Internal widths
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET         = 3'd0,
    CMD_SET         = 3'd1,
    CMD_INSERT      = 3'd2,
    CMD_DELETE      = 3'd3,
    CMD_APPEND      = 3'd4,
    CMD_REMOVE_LAST = 3'd5,
    CMD_LENGTH      = 3'd6
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } array_op_e;

  typedef struct packed {
    array_op_e        kind;
    logic [IDX_W-1:0] pos;
  } array_op_t;

endpackage

>>> sv/iida_array.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iida_array: row of word registers with parallel shift
// Write one entry, shift up from a position (insert) or down to it (delete).
// ----------------------------------------------------------------------------
module iida_array (
  input  logic                             clk_i,
  input  iida_pkg::array_op_t              op_i,
  input  logic [iida_pkg::DATA_WIDTH-1:0]  word_i,
  input  logic [iida_pkg::IDX_W-1:0]       rd_addr_i,
  output logic [iida_pkg::DATA_WIDTH-1:0]  rd_word_o
);

  logic [iida_pkg::DATA_WIDTH-1:0] entries_q [iida_pkg::CAPACITY];

  for (genvar k = 0; k < iida_pkg::CAPACITY; k++) begin : g_slot
    logic at_pos;
    logic above_pos;
    assign at_pos    = (op_i.pos == iida_pkg::IDX_W'(k));
    assign above_pos = (iida_pkg::IDX_W'(k) > op_i.pos);

    always_ff @(posedge clk_i) begin
      case (op_i.kind)
        iida_pkg::OP_WRITE: begin
          if (at_pos) entries_q[k] <= word_i;
        end
        iida_pkg::OP_INSERT: begin
          if (at_pos) begin
            entries_q[k] <= word_i;
          end else if (above_pos) begin
            if (k > 0) entries_q[k] <= entries_q[(k > 0) ? k - 1 : 0];
          end
        end
        iida_pkg::OP_DELETE: begin
          // last slot keeps its (now unused) word
          if ((at_pos || above_pos) && (k < iida_pkg::CAPACITY - 1)) begin
            entries_q[k] <= entries_q[(k < iida_pkg::CAPACITY - 1) ? k + 1 : k];
          end
        end
        default: ;
      endcase
    end
  end

  assign rd_word_o = entries_q[rd_addr_i];

endmodule

>>> sv/iida_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iida_exec: command decode, bounds checks and entry count
// Turns one command into an array operation, status and result fields.
// ----------------------------------------------------------------------------
module iida_exec (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             fire_i,
  input  logic [iida_pkg::CMD_W-1:0]       cmd_i,
  input  logic [iida_pkg::IDX_IN_W-1:0]    idx_i,
  input  logic [iida_pkg::DATA_WIDTH-1:0]  rd_word_i,
  output iida_pkg::array_op_t              op_o,
  output logic [iida_pkg::VAL_W-1:0]       read_value_o,
  output logic [iida_pkg::CNTO_W-1:0]      count_o,
  output iida_pkg::status_e                status_o
);

  logic [iida_pkg::CNT_W-1:0] count_q, count_d;
  logic [iida_pkg::CMP_W-1:0] idx_ext, cnt_ext;
  logic                       full, empty, rd_ok;
  iida_pkg::array_op_t        op;
  iida_pkg::status_e          status;

  assign idx_ext = iida_pkg::CMP_W'(idx_i);
  assign cnt_ext = iida_pkg::CMP_W'(count_q);
  assign full    = (count_q == iida_pkg::CNT_W'(iida_pkg::CAPACITY));
  assign empty   = (count_q == '0);

  always_comb begin
    op.kind = iida_pkg::OP_NONE;
    op.pos  = iida_pkg::IDX_W'(idx_i);
    status  = iida_pkg::ST_OK;
    count_d = count_q;
    rd_ok   = 1'b0;
    unique case (iida_pkg::cmd_e'(cmd_i))
      iida_pkg::CMD_GET: begin
        if (idx_ext < cnt_ext) rd_ok = 1'b1;
        else status = iida_pkg::ST_RANGE;
      end
      iida_pkg::CMD_SET: begin
        if (idx_ext < cnt_ext) op.kind = iida_pkg::OP_WRITE;
        else status = iida_pkg::ST_RANGE;
      end
      iida_pkg::CMD_INSERT: begin
        if (full) begin
          status = iida_pkg::ST_FULL;
        end else if (idx_ext > cnt_ext) begin
          status = iida_pkg::ST_RANGE;
        end else begin
          op.kind = iida_pkg::OP_INSERT;
          count_d = count_q + iida_pkg::CNT_W'(1);
        end
      end
      iida_pkg::CMD_DELETE: begin
        if (empty) begin
          status = iida_pkg::ST_EMPTY;
        end else if (idx_ext >= cnt_ext) begin
          status = iida_pkg::ST_RANGE;
        end else begin
          op.kind = iida_pkg::OP_DELETE;
          count_d = count_q - iida_pkg::CNT_W'(1);
        end
      end
      iida_pkg::CMD_APPEND: begin
        if (full) begin
          status = iida_pkg::ST_FULL;
        end else begin
          op.kind = iida_pkg::OP_WRITE;
          op.pos  = iida_pkg::IDX_W'(count_q);
          count_d = count_q + iida_pkg::CNT_W'(1);
        end
      end
      iida_pkg::CMD_REMOVE_LAST: begin
        if (empty) status = iida_pkg::ST_EMPTY;
        else count_d = count_q - iida_pkg::CNT_W'(1);
      end
      default: ;  // length and unused code: no change
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire_i) begin
      count_q <= count_d;
    end
  end

  assign op_o.kind    = fire_i ? op.kind : iida_pkg::OP_NONE;
  assign op_o.pos     = op.pos;
  assign read_value_o = rd_ok ? iida_pkg::VAL_W'(rd_word_i) : '0;
  assign count_o      = iida_pkg::CNTO_W'(count_d);
  assign status_o     = status;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= iida_pkg::CNT_W'(iida_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_error_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (status != iida_pkg::ST_OK) |=> count_q == $past(count_q))
    else $error("failed command changed the count");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (status == iida_pkg::ST_EMPTY) |-> empty)
    else $error("empty status with entries present");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (status == iida_pkg::ST_FULL) |-> full)
    else $error("full status below capacity");

endmodule

>>> sv/indexed_insert_delete_array_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_delete_array_top: ordered array with insert/delete by index
// Input register, execute over a row of word registers, result
// register.
// ----------------------------------------------------------------------------
// One item in, one item out. Each item carries a command (get, set, insert,
// delete, append, remove last, length), an index and a data word; each result
// carries the word read by a successful get (zero otherwise), the entry count
// after the command and a status (ok, full, empty, index out of range). A
// failing command changes nothing. Items enter at one per cycle while the
// result side keeps taking results: the command is latched in the input
// register, then executed against the entry registers, where the slots at
// and above the index change in parallel on insert or delete, and the result
// lands in the output register. Throughput is set by the output register:
// when the result side stalls, the input register holds one more item and
// then ready drops. Entry contents are not cleared by reset; only the count
// is, so words past the count are never visible.
// ----------------------------------------------------------------------------
module indexed_insert_delete_array_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [iida_pkg::CMD_W-1:0]     command_i,
  input  logic [iida_pkg::IDX_IN_W-1:0]  index_i,
  input  logic [iida_pkg::VAL_W-1:0]     value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [iida_pkg::VAL_W-1:0]     read_value_o,
  output logic [iida_pkg::CNTO_W-1:0]    count_o,
  output logic [iida_pkg::STAT_W-1:0]    status_o
);

  // input register
  logic                          in_valid_q;
  logic [iida_pkg::CMD_W-1:0]    cmd_q;
  logic [iida_pkg::IDX_IN_W-1:0] idx_q;
  logic [iida_pkg::VAL_W-1:0]    val_q;

  // result register
  logic                          out_valid_q;
  logic [iida_pkg::VAL_W-1:0]    read_value_q;
  logic [iida_pkg::CNTO_W-1:0]   count_q;
  logic [iida_pkg::STAT_W-1:0]   status_q;

  logic                            fire;
  iida_pkg::array_op_t             op;
  logic [iida_pkg::DATA_WIDTH-1:0] rd_word;
  logic [iida_pkg::VAL_W-1:0]      ex_read_value;
  logic [iida_pkg::CNTO_W-1:0]     ex_count;
  iida_pkg::status_e               ex_status;

  // execute when the staged item has somewhere to go
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q <= command_i;
      idx_q <= index_i;
      val_q <= value_i;
    end
  end

  iida_exec u_exec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .cmd_i        (cmd_q),
    .idx_i        (idx_q),
    .rd_word_i    (rd_word),
    .op_o         (op),
    .read_value_o (ex_read_value),
    .count_o      (ex_count),
    .status_o     (ex_status)
  );

  iida_array u_array (
    .clk_i     (clk_i),
    .op_i      (op),
    .word_i    (iida_pkg::DATA_WIDTH'(val_q)),
    .rd_addr_i (iida_pkg::IDX_W'(idx_q)),
    .rd_word_o (rd_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      read_value_q <= ex_read_value;
      count_q      <= ex_count;
      status_q     <= ex_status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign count_o      = count_q;
  assign status_o     = status_q;

  a_staged_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q && $stable(cmd_q) && $stable(idx_q))
    else $error("staged item lost while waiting");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !fire)
    else $error("result overwritten while stalled");

  a_fire_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("executed item produced no result");

endmodule

>>> bench/indexed_insert_delete_array_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_delete_array_top_test: self-checking bench for the array
// A queued driver sends commands in bursts. A monitor checks every result
// against a local array model. It covers edge cases first, then about a
// thousand random commands that swing the array between empty and full.
// ----------------------------------------------------------------------------
module indexed_insert_delete_array_top_test;
  import iida_pkg::*;

  // Command code 7 has no name in the package; the block must ignore it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  localparam int RANDOM_ITEMS = 1000;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [IDX_IN_W-1:0] idx;
    logic [VAL_W-1:0]    val;
    bit                  drain_first; // wait until every result is back
  } array_cmd_t;

  typedef struct {
    logic [VAL_W-1:0]  read_value;
    logic [CNTO_W-1:0] count;
    status_e           status;
  } array_result_t;

  // Clock and reset
  logic clk;
  logic rst_n;

  // Input side, driven at the rising edge only
  logic                in_valid = 1'b0;
  logic [CMD_W-1:0]    cmd_r    = '0;
  logic [IDX_IN_W-1:0] idx_r    = '0;
  logic [VAL_W-1:0]    val_r    = '0;
  logic                in_ready_o;

  // Output side
  logic                out_rdy = 1'b0;
  logic                out_valid_o;
  logic [VAL_W-1:0]    read_value_o;
  logic [CNTO_W-1:0]   count_o;
  logic [STAT_W-1:0]   status_o;

  // Commands waiting to go out, and results still owed by the block
  array_cmd_t    cmd_q[$];
  array_result_t result_q[$];

  // Local copy of the array contents and fill level
  logic [DATA_WIDTH-1:0] arr_words[CAPACITY];
  int                    arr_count = 0;

  // Fill level as seen while building stimulus, to aim indexes
  int gen_count = 0;

  int fail_count   = 0;
  int results_seen = 0;

  // Sender burst shaping
  int burst_left = 8;
  int gap_left   = 0;

  // Receiver stall shaping
  int  rx_mode      = 0;
  int  rx_mode_left = 50;
  int  hold_left    = 0;
  bit  long_hold_done = 1'b0;

  indexed_insert_delete_array_top dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .command_i    (cmd_r),
    .index_i      (idx_r),
    .value_i      (val_r),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_rdy),
    .read_value_o (read_value_o),
    .count_o      (count_o),
    .status_o     (status_o)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Array model: applies one command and returns the result it should give.
  // Failing commands leave the array untouched. Full is checked before the
  // index on insert, empty before the index on delete.
  // --------------------------------------------------------------------------
  function automatic array_result_t apply_array_cmd(logic [CMD_W-1:0] cmd,
                                                    logic [IDX_IN_W-1:0] idx,
                                                    logic [VAL_W-1:0] val);
    array_result_t r;
    int pos;
    r.read_value = '0;
    r.status     = ST_OK;
    pos = int'(idx);
    case (cmd)
      CMD_GET: begin
        if (pos < arr_count) r.read_value = VAL_W'(arr_words[pos]);
        else r.status = ST_RANGE;
      end
      CMD_SET: begin
        if (pos < arr_count) arr_words[pos] = val[DATA_WIDTH-1:0];
        else r.status = ST_RANGE;
      end
      CMD_INSERT: begin
        if (arr_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (pos > arr_count) begin
          r.status = ST_RANGE;
        end else begin
          // open a hole at pos, everything above moves up one slot
          for (int k = arr_count; k > pos; k--) arr_words[k] = arr_words[k-1];
          arr_words[pos] = val[DATA_WIDTH-1:0];
          arr_count++;
        end
      end
      CMD_DELETE: begin
        if (arr_count == 0) begin
          r.status = ST_EMPTY;
        end else if (pos >= arr_count) begin
          r.status = ST_RANGE;
        end else begin
          // close the gap, only entries above pos move down
          for (int k = pos; k + 1 < arr_count; k++) arr_words[k] = arr_words[k+1];
          arr_count--;
        end
      end
      CMD_APPEND: begin
        if (arr_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          arr_words[arr_count] = val[DATA_WIDTH-1:0];
          arr_count++;
        end
      end
      CMD_REMOVE_LAST: begin
        if (arr_count == 0) r.status = ST_EMPTY;
        else arr_count--;
      end
      default: ; // length and the unused code change nothing
    endcase
    r.count = CNTO_W'(arr_count);
    return r;
  endfunction

  // Queue one command; track the fill level so later indexes can be aimed
  task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [IDX_IN_W-1:0] idx,
                           logic [VAL_W-1:0] val, bit drain_first = 1'b0);
    array_cmd_t c;
    c.cmd = cmd;
    c.idx = idx;
    c.val = val;
    c.drain_first = drain_first;
    cmd_q.push_back(c);
    case (cmd)
      CMD_INSERT:      if (gen_count < CAPACITY && int'(idx) <= gen_count) gen_count++;
      CMD_APPEND:      if (gen_count < CAPACITY) gen_count++;
      CMD_DELETE:      if (gen_count > 0 && int'(idx) < gen_count) gen_count--;
      CMD_REMOVE_LAST: if (gen_count > 0) gen_count--;
      default: ;
    endcase
  endtask

  task automatic note_failure(string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, what);
  endtask

  // Random word, with all-zero and all-one words mixed in
  function automatic logic [VAL_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic build_stimulus();
    logic [CMD_W-1:0] cmd;
    logic [IDX_IN_W-1:0] idx;
    bit grow;
    int roll;
    int w;

    // ---- Edge cases on an empty array ----
    queue_cmd(CMD_LENGTH, '0, '0);
    queue_cmd(CMD_GET, '0, '0);              // nothing stored yet
    queue_cmd(CMD_DELETE, '0, '0);           // empty wins over index
    queue_cmd(CMD_REMOVE_LAST, '0, '0);
    queue_cmd(CMD_SET, '0, '1);
    queue_cmd(CMD_INSERT, 5'd1, '1);         // past the end
    // ---- Insert at front, middle and end; read back ----
    queue_cmd(CMD_INSERT, '0, '1);
    queue_cmd(CMD_INSERT, '0, '0);
    queue_cmd(CMD_INSERT, 5'd2, 32'h5A5A_A5A5);
    queue_cmd(CMD_GET, 5'd2, '0);
    queue_cmd(CMD_SET, 5'd1, 32'hA5A5_5A5A);
    queue_cmd(CMD_GET, 5'd1, '0);
    queue_cmd(CMD_DELETE, '0, '0);
    queue_cmd(CMD_DELETE, 5'd5, '0);         // past the end
    queue_cmd(CMD_UNUSED, '1, '1);           // ignored code
    queue_cmd(CMD_GET, '1, '0);              // largest index
    // ---- Fill to capacity, then push against the full array ----
    while (gen_count < CAPACITY) queue_cmd(CMD_APPEND, '0, pick_word());
    queue_cmd(CMD_APPEND, '0, '1);
    queue_cmd(CMD_INSERT, '1, '1);           // full wins over index
    queue_cmd(CMD_GET, IDX_IN_W'(CAPACITY - 1), '0);
    queue_cmd(CMD_DELETE, IDX_IN_W'(CAPACITY - 1), '0);
    queue_cmd(CMD_REMOVE_LAST, '0, '0);

    // ---- Random part: swing between filling and draining ----
    grow = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (gen_count == CAPACITY) grow = 1'b0;
      else if (gen_count == 0) grow = 1'b1;
      else if ($urandom_range(0, 39) == 0) grow = ~grow;

      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        // noise: any code, any index
        queue_cmd(CMD_W'($urandom_range(0, 7)), IDX_IN_W'($urandom_range(0, 31)),
                  pick_word(), (n % 250) == 125);
      end else begin
        w = $urandom_range(0, 99);
        if (grow) begin
          if (w < 30) cmd = CMD_INSERT;
          else if (w < 55) cmd = CMD_APPEND;
          else if (w < 70) cmd = CMD_GET;
          else if (w < 80) cmd = CMD_SET;
          else if (w < 90) cmd = CMD_DELETE;
          else if (w < 95) cmd = CMD_REMOVE_LAST;
          else cmd = CMD_LENGTH;
        end else begin
          if (w < 30) cmd = CMD_DELETE;
          else if (w < 50) cmd = CMD_REMOVE_LAST;
          else if (w < 65) cmd = CMD_GET;
          else if (w < 75) cmd = CMD_SET;
          else if (w < 85) cmd = CMD_INSERT;
          else if (w < 95) cmd = CMD_APPEND;
          else cmd = CMD_LENGTH;
        end
        if (cmd == CMD_INSERT) idx = IDX_IN_W'($urandom_range(0, gen_count));
        else if (gen_count > 0) idx = IDX_IN_W'($urandom_range(0, gen_count - 1));
        else idx = '0;
        queue_cmd(cmd, idx, pick_word(), (n % 250) == 125);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: one item per handshake, in bursts mostly separated by idle gaps. An item
  // flagged drain_first is held back until nothing is in flight.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    array_cmd_t nxt;
    if (rst_n && !(in_valid && !in_ready_o)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_q.size() != 0 &&
                   !(cmd_q[0].drain_first && (in_valid || result_q.size() != 0))) begin
        nxt = cmd_q.pop_front();
        in_valid <= 1'b1;
        cmd_r <= nxt.cmd;
        idx_r <= nxt.idx;
        val_r <= nxt.val;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // now and then a long back-to-back run with no gap at all
          if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(20, 80);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = $urandom_range(1, 10);
          end
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready follows a changing pattern. Once, a long hold-off lets
  // the block fill up and push back on its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic rdy;
    if (rst_n) begin
      if (!long_hold_done && results_seen >= 300) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 200);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0: rdy = 1'b1;                            // no stalls
        1: rdy = 1'($urandom_range(0, 1));        // half the time
        2: rdy = ($urandom_range(0, 9) != 0);     // rare stalls
        default: rdy = ($urandom_range(0, 3) == 0); // mostly stalled
      endcase
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end
      out_rdy <= rdy;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks the outgoing result first, then records the expectation
  // for an item taken at this edge. Latency keeps the two apart.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    array_result_t exp_r;
    if (rst_n) begin
      if (out_valid_o && out_rdy) begin
        results_seen++;
        if (result_q.size() == 0) begin
          note_failure($sformatf("result with nothing pending: rd=%h cnt=%0d st=%0d",
                                 read_value_o, count_o, status_o));
        end else begin
          exp_r = result_q.pop_front();
          if (read_value_o !== exp_r.read_value)
            note_failure($sformatf("read_value exp %h got %h",
                                   exp_r.read_value, read_value_o));
          if (count_o !== exp_r.count)
            note_failure($sformatf("count exp %0d got %0d", exp_r.count, count_o));
          if (status_o !== exp_r.status)
            note_failure($sformatf("status exp %s got %0d",
                                   exp_r.status.name(), status_o));
        end
      end
      if (in_valid && in_ready_o)
        result_q.push_back(apply_array_cmd(cmd_r, idx_r, val_r));
    end
  end

  // Main sequence: reset, stimulus, drain, verdict
  initial begin
    rst_n = 1'b0;
    build_stimulus();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || in_valid) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    // wait on to catch any stray result
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
